@@ src/spiral_index_to_coordinates_macros.svh @@
// ---------------------------------------------------------------------------
// Spiral index to coordinates: assertion macros
// Immediate-style wrappers for concurrent checks on the block clock/reset.
// ---------------------------------------------------------------------------
`ifndef SPIRAL_INDEX_TO_COORDINATES_MACROS_SVH
`define SPIRAL_INDEX_TO_COORDINATES_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SITC_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sitc check failed");

// next-cycle implication
`define SITC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sitc check failed");

`else

`define SITC_ASSERT(lbl, ante, cons)
`define SITC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/sitc_pkg.sv @@
// ---------------------------------------------------------------------------
// Spiral index to coordinates: package
// Control word layout, step numbers and the sequencer program.
// ---------------------------------------------------------------------------
package sitc_pkg;

   localparam int COORD_BITS    = 17;
   localparam int RSP_DATA_BITS = 40;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - 2 * COORD_BITS;
   localparam int STEP_BITS     = 3;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_SQRT = 3'd1;
   localparam step_type STEP_BASE = 3'd2;
   localparam step_type STEP_SIDE = 3'd3;
   localparam step_type STEP_EMIT = 3'd4;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_SQRT,
      OP_BASE,
      OP_SIDE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_NO_REQ,
      COND_CNT_MORE,
      COND_POS_GE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jmp;
      step_type nxt;
   } ctrl_word_type;

   // program: taken jump when cond holds, else fall to nxt
   function automatic ctrl_word_type sitc_rom(input step_type pc);
      ctrl_word_type w;
      case (pc)
         STEP_IDLE: w = '{op: OP_LOAD, cond: COND_NO_REQ,   jmp: STEP_IDLE, nxt: STEP_SQRT};
         STEP_SQRT: w = '{op: OP_SQRT, cond: COND_CNT_MORE, jmp: STEP_SQRT, nxt: STEP_BASE};
         STEP_BASE: w = '{op: OP_BASE, cond: COND_NONE,     jmp: STEP_BASE, nxt: STEP_SIDE};
         STEP_SIDE: w = '{op: OP_SIDE, cond: COND_POS_GE,   jmp: STEP_SIDE, nxt: STEP_EMIT};
         STEP_EMIT: w = '{op: OP_EMIT, cond: COND_OUT_BUSY, jmp: STEP_EMIT, nxt: STEP_IDLE};
         default:   w = '{op: OP_LOAD, cond: COND_NONE,     jmp: STEP_IDLE, nxt: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ src/spiral_index_to_coordinates.sv @@
// ---------------------------------------------------------------------------
// Spiral index to coordinates
// Maps a step index along a square spiral around the origin to its signed
// (x, y) grid position, driven by a small microcoded sequencer.
// ---------------------------------------------------------------------------
//  channel  | ports      | contents
//  ---------+------------+------------------------------------------------
//  request  | req_t*     | tdata: step_index (INDEX_BITS, unsigned)
//  response | rsp_t*     | tdata: pos_x (17, signed), pos_y (17, signed)
//
//  Each item passes load, the bit-pair square-root loop (one compare/subtract
//  per step), the base step, the side search and emit. The loop does most of
//  the work, and the side search subtracts 2k up to three times.
//  A finished result sits in the output register, and the next request is
//  taken while it waits. Reset is synchronous and clears the sequencer step
//  and the response valid flag.
// ---------------------------------------------------------------------------
`include "spiral_index_to_coordinates_macros.svh"

module spiral_index_to_coordinates #(
   parameter int INDEX_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((INDEX_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // step_index
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [sitc_pkg::RSP_DATA_BITS-1:0] rsp_tdata         // pos_x, pos_y
);
   import sitc_pkg::*;

   localparam int ROOT_BITS = (INDEX_BITS + 1) / 2;
   localparam int WORK_BITS = 2 * ROOT_BITS;
   localparam int POS_BITS  = ROOT_BITS + 2;
   localparam int LEN_BITS  = ROOT_BITS + 1;
   localparam int CNT_BITS  = $clog2(ROOT_BITS + 1);

   step_type               pc_ff, pc_in;
   logic [WORK_BITS-1:0]   v_ff, v_in;
   logic [WORK_BITS-1:0]   root_ff, root_in;
   logic [WORK_BITS-1:0]   bit_ff, bit_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [1:0]             side_ff, side_in;
   logic [COORD_BITS-1:0]  x_ff, x_in;
   logic [COORD_BITS-1:0]  y_ff, y_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   ctrl_word_type          word;
   logic                   req_fire;
   logic                   rsp_busy;
   logic                   cond_hit;
   logic [WORK_BITS:0]     trial;
   logic                   take;
   logic                   pos_ge_len;
   logic [ROOT_BITS-1:0]   s;
   logic [COORD_BITS-1:0]  kc, oc, one;

   assign word       = sitc_rom(pc_ff);
   assign req_tready = (pc_ff == STEP_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_busy   = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, y_ff, x_ff};

   assign trial      = {1'b0, root_ff} + {1'b0, bit_ff};
   assign take       = {1'b0, v_ff} >= trial;
   assign pos_ge_len = (len_ff != '0) && (pos_ff >= POS_BITS'(len_ff));
   assign s          = root_ff[ROOT_BITS-1:0];
   assign kc         = COORD_BITS'(len_ff[LEN_BITS-1:1]);
   assign oc         = COORD_BITS'(pos_ff);
   assign one        = COORD_BITS'(1);

   always_comb begin
      case (word.cond)
         COND_NO_REQ:   cond_hit = !req_fire;
         COND_CNT_MORE: cond_hit = (cnt_ff != CNT_BITS'(1));
         COND_POS_GE:   cond_hit = pos_ge_len;
         COND_OUT_BUSY: cond_hit = rsp_busy;
         default:       cond_hit = 1'b0;
      endcase
      pc_in = cond_hit ? word.jmp : word.nxt;
   end

   always_comb begin
      v_in         = v_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      side_in      = side_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      case (word.op)
         OP_LOAD: begin
            if (req_fire) begin
               v_in    = WORK_BITS'(req_tdata[INDEX_BITS-1:0]);
               root_in = '0;
               bit_in  = WORK_BITS'(1) << (WORK_BITS - 2);
               cnt_in  = CNT_BITS'(ROOT_BITS);
            end
         end
         OP_SQRT: begin
            // one result bit per step; v ends as the remainder n - s*s
            if (take) begin
               v_in    = v_ff - trial[WORK_BITS-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - CNT_BITS'(1);
         end
         OP_BASE: begin
            // odd root: s = 2k-1, offset is the remainder; even root: s = 2k,
            // add the squared difference s*s - (s-1)*(s-1) = 2s-1 to the remainder
            if (s[0]) begin
               pos_in = v_ff[POS_BITS-1:0];
               len_in = LEN_BITS'(s) + LEN_BITS'(1);
            end else begin
               pos_in = v_ff[POS_BITS-1:0] + {1'b0, s, 1'b0} - POS_BITS'(1);
               len_in = LEN_BITS'(s);
            end
            side_in = 2'd0;
         end
         OP_SIDE: begin
            if (pos_ge_len) begin
               pos_in  = pos_ff - POS_BITS'(len_ff);
               side_in = side_ff + 2'd1;
            end
         end
         OP_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               if (len_ff == '0) begin
                  // origin
                  x_in = '0;
                  y_in = '0;
               end else begin
                  case (side_ff)
                     2'd0: begin
                        x_in = -kc;
                        y_in = kc - one - oc;
                     end
                     2'd1: begin
                        x_in = oc + one - kc;
                        y_in = -kc;
                     end
                     2'd2: begin
                        x_in = kc;
                        y_in = oc + one - kc;
                     end
                     default: begin
                        x_in = kc - one - oc;
                        y_in = kc;
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff    <= v_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      pos_ff  <= pos_in;
      len_ff  <= len_in;
      side_ff <= side_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   `SITC_ASSERT(a_sqrt_cnt_live, pc_ff == STEP_SQRT, cnt_ff != '0)
   `SITC_ASSERT(a_sqrt_rem_bound, pc_ff == STEP_BASE, v_ff <= (root_ff << 1))
   `SITC_ASSERT(a_side_bound, pc_ff == STEP_SIDE && side_ff == 2'd3, !pos_ge_len)
   `SITC_ASSERT_NEXT(a_emit_valid, pc_ff == STEP_EMIT && !rsp_busy, rsp_valid_ff)

endmodule

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// Spiral index to coordinates: testbench
// Streams step indices into the block and checks every (x, y) result
// against a spiral predictor in the bench: ring corners, ring boundaries,
// the full 32-bit range and random values, with random idling on both sides.
// ---------------------------------------------------------------------------
module testbench;
   import sitc_pkg::*;

   localparam int INDEX_BITS      = 32;
   localparam int REQ_DATA_BITS   = ((INDEX_BITS + 7) / 8) * 8;
   localparam int RANDOM_ITEMS    = 1926;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [31:0] CORNER_INDICES [24] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
      32'd10, 32'd24, 32'd25, 32'd48, 32'd49, 32'h0000FFFF, 32'h00010000,
      32'h55555555, 32'hAAAAAAAA, 32'h80000000, 32'hFFFE0000, 32'hFFFE0001,
      32'hFFFF0000, 32'hFFFFFFFF
   };

   typedef enum logic [1:0] {
      SIDE_LEFT,
      SIDE_BOTTOM,
      SIDE_RIGHT,
      SIDE_TOP
   } ring_side_type;

   typedef struct {
      logic [INDEX_BITS-1:0]        step_index;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
   } spiral_point_type;

   class coord_tracker;
      spiral_point_type expected_q[$];
      int               mismatches;
      int               requests;
      int               responses;

      function automatic spiral_point_type spiral_point(input logic [INDEX_BITS-1:0] idx);
         spiral_point_type pt;
         longint unsigned  n, root, trial, base, span, pos, off;
         longint           k, x, y;
         ring_side_type    side;
         n = idx;
         pt.step_index = idx;
         x = 0;
         y = 0;
         if (n != 0) begin
            // integer square root, one result bit at a time
            root = 0;
            for (int b = (INDEX_BITS + 1) / 2; b >= 0; b--) begin
               trial = root | (64'd1 << b);
               if (trial * trial <= n) begin
                  root = trial;
               end
            end
            k    = longint'((root + 1) >> 1);
            base = longint'(2 * k - 1) * longint'(2 * k - 1);
            span = 2 * k;
            pos  = n - base;
            off  = pos % span;
            side = ring_side_type'((pos / span) & 3);
            case (side)
               SIDE_LEFT: begin
                  x = -k;
                  y = k - 1 - longint'(off);
               end
               SIDE_BOTTOM: begin
                  x = longint'(off) + 1 - k;
                  y = -k;
               end
               SIDE_RIGHT: begin
                  x = k;
                  y = longint'(off) + 1 - k;
               end
               default: begin
                  x = k - 1 - longint'(off);
                  y = k;
               end
            endcase
         end
         pt.pos_x = x[COORD_BITS-1:0];
         pt.pos_y = y[COORD_BITS-1:0];
         return pt;
      endfunction

      function void note_request(input logic [INDEX_BITS-1:0] idx);
         requests++;
         expected_q.push_back(spiral_point(idx));
      endfunction

      function void check_response(input logic [RSP_DATA_BITS-1:0] data);
         spiral_point_type             want;
         logic signed [COORD_BITS-1:0] got_x;
         logic signed [COORD_BITS-1:0] got_y;
         logic [RSP_PAD_BITS-1:0]      got_pad;
         responses++;
         got_x   = data[COORD_BITS-1:0];
         got_y   = data[2*COORD_BITS-1:COORD_BITS];
         got_pad = data[RSP_DATA_BITS-1:2*COORD_BITS];
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("response with nothing outstanding: tdata %h", data);
            end
            return;
         end
         want = expected_q.pop_front();
         if (got_x !== want.pos_x || got_y !== want.pos_y || got_pad !== '0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("index %0d: expected (%0d, %0d), got (%0d, %0d), pad %h",
                        want.step_index, want.pos_x, want.pos_y, got_x, got_y, got_pad);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;  // step_index
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;       // pos_x, pos_y, zero pad

   coord_tracker tracker = new();
   bit           calm = 1'b0;
   bit           hold_request = 1'b0;
   int           cycle_count = 0;
   int           hold_count;
   bit           failed;

   spiral_index_to_coordinates #(
      .INDEX_BITS(INDEX_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, tracker.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // note every transfer on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.note_request(req_tdata[INDEX_BITS-1:0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_response(rsp_tdata);
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            hold_count = 0;
            while (hold_count < RSP_HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 22);
         end
      end
   end

   task automatic send_index(input logic [INDEX_BITS-1:0] value);
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (!calm && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [INDEX_BITS-1:0] pick_index();
      longint unsigned odd, k, value;
      int              pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         value = $urandom();
      end else if (pick < 55) begin
         value = $urandom_range(400);
      end else if (pick < 78) begin
         // around a ring start (odd square)
         odd   = 2 * $urandom_range(32767) + 1;
         value = odd * odd + $urandom_range(2) - 1;
         if (odd == 1 && value > 2) begin
            value = 0;
         end
      end else begin
         // a side corner of a random ring
         k     = ($urandom_range(3) == 0) ? $urandom_range(1, 32768) : $urandom_range(1, 40);
         value = (2 * k - 1) * (2 * k - 1) + $urandom_range(3) * 2 * k;
         value = value + (($urandom_range(1) == 0) ? 0 : 2 * k - 1);
      end
      if (value > 64'hFFFF_FFFF) begin
         value = 64'hFFFF_FFFF;
      end
      return value[INDEX_BITS-1:0];
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (CORNER_INDICES[i]) begin
         send_index(CORNER_INDICES[i]);
      end
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300) begin
            hold_request = 1'b1;
         end
         calm = (i >= 700 && i < 1000);
         if (i == 1200) begin
            wait_drained();
         end
         send_index(pick_index());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      failed = (tracker.mismatches != 0) || (tracker.pending() != 0);
      $display("%0d step indices sent, %0d coordinate pairs checked, %0d mismatches",
               tracker.requests, tracker.responses, tracker.mismatches);
      $display("covered origin, ring and side corners up to the outermost ring, %s",
               "full-range random indices, a long result hold-off and a full drain");
      if (!failed) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/sitc_pkg.sv
src/spiral_index_to_coordinates.sv
bench/testbench.sv
